// ----- src/mcwo_pkg.sv -----
// Shared types and constants of the masked cutout with outline unit.
package mcwo_pkg;

    // Depth of the queue between the classifier and the neighborhood engine.
    localparam int Q_DEPTH = 4;
    localparam int QAW     = 2;

    // Field widths of the stream payloads and the configuration register.
    localparam int CFG_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 32;
    localparam int POS_W   = 5;
    localparam int IN_W    = 4 * CHAN_W + COLOR_W;
    localparam int OUT_W   = 48;

    // Mask alpha that a target match requires.
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // One classified pixel as it travels through the queue.
    typedef struct packed {
        logic               tflag;
        logic               bflag;
        logic [COLOR_W-1:0] base;
    } t_entry;

endpackage

// ----- src/mcwo_front.sv -----
// Input side: holds the target color and classifies each incoming mask pixel.
module mcwo_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mcwo_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    input  logic [mcwo_pkg::IN_W-1:0]    i_data,
    output logic                         o_push,
    output mcwo_pkg::t_entry             o_entry
);
    import mcwo_pkg::*;

    logic [CFG_W-1:0]  r_target;
    logic [CHAN_W-1:0] w_red;
    logic [CHAN_W-1:0] w_green;
    logic [CHAN_W-1:0] w_blue;
    logic [CHAN_W-1:0] w_alpha;
    logic [CFG_W-1:0]  w_rgb;

    // Target color register; the user writes it only while idle, unenforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_data;
        end
    end

    // Unpack the input transfer.
    assign w_red   = i_data[CHAN_W-1:0];
    assign w_green = i_data[2*CHAN_W-1:CHAN_W];
    assign w_blue  = i_data[3*CHAN_W-1:2*CHAN_W];
    assign w_alpha = i_data[4*CHAN_W-1:3*CHAN_W];
    assign w_rgb   = {w_red, w_green, w_blue};

    // Classify the pixel with the target color in force at its arrival.
    always_comb begin
        o_entry.tflag = (w_alpha == ALPHA_OPAQUE) && (w_rgb == r_target);
        o_entry.bflag = (w_rgb == '0);
        o_entry.base  = i_data[IN_W-1:4*CHAN_W];
    end

    assign o_push = i_valid;

endmodule

// ----- src/mcwo_queue.sv -----
// Short first-in first-out queue of classified pixels.
module mcwo_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mcwo_pkg::t_entry i_entry,
    output logic             o_ready,
    output logic             o_valid,
    output mcwo_pkg::t_entry o_head,
    input  logic             i_pop
);
    import mcwo_pkg::*;

    t_entry         r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_ready = (r_cnt < (QAW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- src/mcwo_back.sv -----
// Output side: flag line buffers, base row store, neighborhood test and result register.
module mcwo_back #(
    parameter int WINDOW_WIDTH  = 32,
    parameter int WINDOW_HEIGHT = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  mcwo_pkg::t_entry               i_head,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_opaque,
    output logic [mcwo_pkg::COLOR_W-1:0]   o_color,
    output logic [mcwo_pkg::POS_W-1:0]     o_col,
    output logic [mcwo_pkg::POS_W-1:0]     o_row,
    output logic                           o_last
);
    import mcwo_pkg::*;

    localparam int CW  = $clog2(WINDOW_WIDTH);
    localparam int RW  = $clog2(WINDOW_HEIGHT);
    localparam int TL  = 2 * WINDOW_WIDTH + 3;
    localparam int BL  = WINDOW_WIDTH + 2;
    localparam int FW  = $clog2(WINDOW_WIDTH + 2);
    localparam int MD  = 2 * (2 ** CW);
    // Tap places in the target line once the new pixel is shifted in.
    localparam int T_UL = 2 * WINDOW_WIDTH + 2;
    localparam int T_U  = 2 * WINDOW_WIDTH + 1;
    localparam int T_UR = 2 * WINDOW_WIDTH;
    localparam int T_L  = WINDOW_WIDTH + 2;
    localparam int T_C  = WINDOW_WIDTH + 1;
    localparam int T_R  = WINDOW_WIDTH;
    localparam int T_DL = 2;
    localparam int T_D  = 1;
    localparam int T_DR = 0;

    logic [TL-1:0]      r_tline;
    logic [TL-1:0]      n_tline;
    logic [BL-1:0]      r_bline;
    logic [BL-1:0]      n_bline;
    logic [COLOR_W-1:0] r_mem [MD];
    logic [COLOR_W-1:0] r_rdata;
    logic [CW-1:0]      r_in_col;
    logic [RW-1:0]      r_in_row;
    logic [CW-1:0]      r_c_col;
    logic [RW-1:0]      r_c_row;
    logic [FW-1:0]      r_flush_left;
    logic               r_valid;
    logic               r_opaque;
    logic               r_last;
    logic [POS_W-1:0]   r_col;
    logic [POS_W-1:0]   r_row;
    logic               w_flushing;
    logic               w_in_last;
    logic               w_emit;
    logic               w_step;
    logic               w_fire;
    logic               w_slot;
    logic               w_up;
    logic               w_down;
    logic               w_left;
    logic               w_right;
    logic               w_nbr;
    logic               w_opaque;

    assign w_flushing = (r_flush_left != '0);
    assign w_in_last  = (r_in_row == RW'(WINDOW_HEIGHT - 1)) &&
                        (r_in_col == CW'(WINDOW_WIDTH - 1));
    // A pixel yields a result once a full row and one pixel lie behind it.
    assign w_emit     = w_flushing || (r_in_row > RW'(1)) ||
                        ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign w_step     = w_flushing || i_valid;
    assign w_slot     = !r_valid || i_ready;
    assign w_fire     = w_step && (!w_emit || w_slot);
    assign o_pop      = w_fire && !w_flushing;

    // Flag lines after this step: a flush shifts in cleared flags.
    assign n_tline = {r_tline[TL-2:0], !w_flushing && i_head.tflag};
    assign n_bline = {r_bline[BL-2:0], !w_flushing && i_head.bflag};

    // Neighbors outside the window never count.
    assign w_up    = (r_c_row != '0);
    assign w_down  = (r_c_row != RW'(WINDOW_HEIGHT - 1));
    assign w_left  = (r_c_col != '0);
    assign w_right = (r_c_col != CW'(WINDOW_WIDTH - 1));

    // Eight-neighbor target test around the center pixel.
    always_comb begin
        w_nbr = (w_up && (n_tline[T_U] || (w_left && n_tline[T_UL]) ||
                          (w_right && n_tline[T_UR]))) ||
                (w_left && n_tline[T_L]) || (w_right && n_tline[T_R]) ||
                (w_down && (n_tline[T_D] || (w_left && n_tline[T_DL]) ||
                            (w_right && n_tline[T_DR])));
        w_opaque = n_tline[T_C] || (n_bline[T_C] && w_nbr);
    end

    // Flag line shift registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tline <= '0;
            r_bline <= '0;
        end else if (w_fire) begin
            r_tline <= n_tline;
            r_bline <= n_bline;
        end
    end

    // Two-row base store: write the new pixel, read the center pixel.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mem[{r_in_row[0], r_in_col}] <= i_head.base;
        end
        if (w_fire && w_emit) begin
            r_rdata <= r_mem[{r_c_row[0], r_c_col}];
        end
    end

    // Position counters and the end-of-window flush.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_c_col      <= '0;
            r_c_row      <= '0;
            r_flush_left <= '0;
        end else if (w_fire) begin
            if (w_flushing) begin
                r_flush_left <= r_flush_left - 1'b1;
            end else begin
                if (w_in_last) begin
                    r_flush_left <= FW'(WINDOW_WIDTH + 1);
                end
                if (r_in_col == CW'(WINDOW_WIDTH - 1)) begin
                    r_in_col <= '0;
                    r_in_row <= (r_in_row == RW'(WINDOW_HEIGHT - 1)) ? '0 : r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
            if (w_emit) begin
                if (r_c_col == CW'(WINDOW_WIDTH - 1)) begin
                    r_c_col <= '0;
                    r_c_row <= (r_c_row == RW'(WINDOW_HEIGHT - 1)) ? '0 : r_c_row + 1'b1;
                end else begin
                    r_c_col <= r_c_col + 1'b1;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_opaque <= w_opaque;
            r_col    <= POS_W'(r_c_col);
            r_row    <= POS_W'(r_c_row);
            r_last   <= w_flushing ? (r_flush_left == FW'(1)) : !w_in_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_opaque = r_opaque;
    assign o_color  = r_opaque ? r_rdata : '0;
    assign o_col    = r_col;
    assign o_row    = r_row;
    assign o_last   = r_last;

endmodule

// ----- src/masked_cutout_with_outline_unit.sv -----
// Top level of the masked cutout with outline unit.
// Pixels of a WINDOW_WIDTH x WINDOW_HEIGHT window enter in raster order, one transfer per
// cycle while the queue has room, and each yields the result for the pixel one row and one
// pixel earlier; the first WINDOW_WIDTH + 1 pixels of a window yield none. The last pixel
// of a window yields WINDOW_WIDTH + 2 results, and while the extra results of that flush
// are made the neighborhood engine takes no new pixel; a four-entry queue keeps accepting
// input until it fills. Sustained rate is one pixel per cycle while the output is not
// stalled and no flush runs, set by the single-step shift of the flag line buffers.
// A pixel is opaque when its mask matches the target color with full alpha, or when its
// mask is black and one of its eight in-window neighbors matches.
module masked_cutout_with_outline_unit #(
    parameter int WINDOW_WIDTH  = 32,
    parameter int WINDOW_HEIGHT = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mcwo_pkg::CFG_W-1:0]     i_cfg_data,    // target color: blue, green, red
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: mask_red, mask_green, mask_blue, mask_alpha, base_color
    input  logic [mcwo_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: pixel_color, out_col, out_row, zero fill
    output logic [mcwo_pkg::OUT_W-1:0]     m_axis_tdata,
    output logic                           m_axis_tuser,  // tuser: pixel_opaque
    output logic                           m_axis_tlast   // tlast: last_of_run
);
    import mcwo_pkg::*;

    t_entry             w_entry;
    t_entry             w_head;
    logic               w_push;
    logic               w_head_valid;
    logic               w_pop;
    logic [COLOR_W-1:0] w_color;
    logic [POS_W-1:0]   w_col;
    logic [POS_W-1:0]   w_row;

    // Classifier and target register.
    mcwo_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_data     (s_axis_tdata),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    // Queue between classifier and neighborhood engine.
    mcwo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_ready (s_axis_tready),
        .o_valid (w_head_valid),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // Neighborhood engine and result register.
    mcwo_back #(
        .WINDOW_WIDTH  (WINDOW_WIDTH),
        .WINDOW_HEIGHT (WINDOW_HEIGHT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_head_valid),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_opaque (m_axis_tuser),
        .o_color  (w_color),
        .o_col    (w_col),
        .o_row    (w_row),
        .o_last   (m_axis_tlast)
    );

    // Pack the result transfer.
    assign m_axis_tdata = {(OUT_W - COLOR_W - 2 * POS_W)'(0), w_row, w_col, w_color};

endmodule

// ----- tb/tb_masked_cutout_with_outline_unit.sv -----
// Testbench for the masked cutout with outline unit: streamed windows checked by a predictor.
`timescale 1ns / 100ps

module tb_masked_cutout_with_outline_unit;

    import mcwo_pkg::*;

    localparam int WW         = 32;
    localparam int WH         = 32;
    localparam int PROBE_N    = 25;
    localparam int IDLE_WAIT  = 40;
    localparam int RX_HOLD    = 300;
    localparam int HOLD_AFTER = 100;

    localparam logic [CFG_W-1:0] TGT_A = 24'hA5C30F;

    // One expected output pixel.
    typedef struct packed {
        logic               opaque;
        logic [COLOR_W-1:0] color;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic               last;
    } cut_px_t;

    // One directed input pixel; quiet marks a transfer known to cause no result.
    typedef struct packed {
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
        logic [CHAN_W-1:0]  a;
        logic [COLOR_W-1:0] base;
        logic               quiet;
    } probe_px_t;

    // Directed pixels at the top left of the first window, target TGT_A.
    // All of them fall in the window start, so none causes a result of its own.
    probe_px_t probe_rows [0:PROBE_N-1] = '{
        '{8'hA5, 8'hC3, 8'h0F, 8'hFF, 32'h00000000, 1'b1},   // target, full alpha
        '{8'hA5, 8'hC3, 8'h0F, 8'hFE, 32'hFFFFFFFF, 1'b1},   // target, alpha one short
        '{8'h00, 8'h00, 8'h00, 8'h00, 32'hDEADBEEF, 1'b1},   // black, alpha zero
        '{8'h00, 8'h00, 8'h00, 8'hFF, 32'hFFFFFFFF, 1'b1},   // black, alpha full
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h12345678, 1'b1},
        '{8'hFF, 8'hFF, 8'hFF, 8'h00, 32'h87654321, 1'b1},
        '{8'hA5, 8'hC3, 8'h0E, 8'hFF, 32'h11111111, 1'b1},   // blue off by one
        '{8'hA4, 8'hC3, 8'h0F, 8'hFF, 32'h22222222, 1'b1},   // red off by one
        '{8'hA5, 8'hC2, 8'h0F, 8'hFF, 32'h33333333, 1'b1},   // green off by one
        '{8'h00, 8'h00, 8'h01, 8'hFF, 32'h44444444, 1'b1},   // nearly black
        '{8'h01, 8'h00, 8'h00, 8'h00, 32'h55555555, 1'b1},
        '{8'h00, 8'h01, 8'h00, 8'h80, 32'h66666666, 1'b1},
        '{8'hA5, 8'hC3, 8'h0F, 8'hFF, 32'h80000000, 1'b1},
        '{8'hA5, 8'hC3, 8'h0F, 8'h00, 32'h00000001, 1'b1},
        '{8'h5A, 8'h3C, 8'hF0, 8'hFF, 32'h77777777, 1'b1},   // complement of target
        '{8'h00, 8'h00, 8'h00, 8'h7F, 32'h88888888, 1'b1},
        '{8'hA5, 8'hC3, 8'h0F, 8'hFF, 32'hFFFFFFFF, 1'b1},
        '{8'h00, 8'h00, 8'h00, 8'hFF, 32'h0F0F0F0F, 1'b1},
        '{8'hA5, 8'hC3, 8'h0F, 8'hFF, 32'hF0F0F0F0, 1'b1},
        '{8'h80, 8'h80, 8'h80, 8'h80, 32'hAAAAAAAA, 1'b1},
        '{8'h7F, 8'h7F, 8'h7F, 8'h7F, 32'h55555555, 1'b1},
        '{8'h00, 8'h00, 8'h00, 8'h00, 32'h00000000, 1'b1},
        '{8'hA5, 8'hC3, 8'h0F, 8'hFF, 32'h01020304, 1'b1},
        '{8'hFF, 8'h00, 8'hFF, 8'hFF, 32'h99999999, 1'b1},
        '{8'h00, 8'hFF, 8'h00, 8'h01, 32'hCCCCCCCC, 1'b1}
    };

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               cfg_we   = 1'b0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               s_valid  = 1'b0;
    logic [IN_W-1:0]    s_data   = '0;
    logic               m_ready  = 1'b0;
    logic               s_axis_tready;
    logic               m_axis_tvalid;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    // Predictor state: flag rows, base rows, window position and target.
    logic               tgt_rows  [3][WW];
    logic               blk_rows  [2][WW];
    logic [COLOR_W-1:0] base_rows [2][WW];
    int                 col_pos   = 0;
    int                 row_pos   = 0;
    logic [CFG_W-1:0]   tgt_color = '0;

    cut_px_t cut_expected [$];
    int      n_fail    = 0;
    int      n_results = 0;
    int      tx_calm   = 0;
    int      rx_calm   = 0;

    masked_cutout_with_outline_unit #(
        .WINDOW_WIDTH  (WW),
        .WINDOW_HEIGHT (WH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Clear the predictor rows so that they match the state after reset.
    initial begin
        for (int i = 0; i < WW; i++) begin
            for (int k = 0; k < 3; k++) tgt_rows[k][i] = 1'b0;
            for (int k = 0; k < 2; k++) begin
                blk_rows[k][i]  = 1'b0;
                base_rows[k][i] = '0;
            end
        end
    end

    // Gap length: mostly none or short, now and then long, with calm stretches.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r < 2) begin
            calm = $urandom_range(30, 80);
            return 0;
        end
        if (r < 110) return 0;
        if (r < 180) return $urandom_range(1, 3);
        if (r < 196) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Target match at a window position; positions outside the window never match.
    function automatic logic tgt_hit(int r, int c);
        if (r < 0 || r >= WH || c < 0 || c >= WW) return 1'b0;
        return tgt_rows[r % 3][c];
    endfunction

    // Output pixel for one window position.
    function automatic cut_px_t cut_pixel(int r, int c);
        cut_px_t px;
        logic    on;
        on = tgt_hit(r, c);
        if (!on && blk_rows[r % 2][c]) begin
            for (int dr = -1; dr <= 1; dr++)
                for (int dc = -1; dc <= 1; dc++)
                    if ((dr != 0 || dc != 0) && tgt_hit(r + dr, c + dc)) on = 1'b1;
        end
        px.opaque = on;
        px.color  = on ? base_rows[r % 2][c] : '0;
        px.col    = 5'(c);
        px.row    = 5'(r);
        px.last   = 1'b0;
        return px;
    endfunction

    // Advance the predictor by one accepted pixel and queue the results it causes.
    task automatic predict_pixel(input logic [7:0] r, g, b, a, input logic [31:0] base,
                                 input logic quiet);
        logic [CFG_W-1:0] rgb;
        int               pos;
        int               first;
        int               fin;
        logic             last;
        cut_px_t          px;
        rgb = {r, g, b};
        tgt_rows[row_pos % 3][col_pos]  = (a == ALPHA_OPAQUE) && (rgb == tgt_color);
        blk_rows[row_pos % 2][col_pos]  = (rgb == '0);
        base_rows[row_pos % 2][col_pos] = base;
        pos  = row_pos * WW + col_pos;
        last = (row_pos == WH - 1) && (col_pos == WW - 1);
        if (pos >= WW + 1 || last) begin
            first = pos - (WW + 1);
            fin   = last ? WW * WH - 1 : first;
            if (first < 0) first = 0;
            for (int q = first; q <= fin; q++) begin
                px      = cut_pixel(q / WW, q % WW);
                px.last = (q == fin);
                if (!quiet) cut_expected.push_back(px);
            end
        end
        if (col_pos == WW - 1) begin
            col_pos = 0;
            row_pos = (row_pos == WH - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    // Offer one pixel after a random gap and hold it until the transfer.
    task automatic send_pixel(input logic [7:0] r, g, b, a, input logic [31:0] base,
                              input logic quiet);
        int gap;
        bit took;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {base, a, b, g, r};
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        predict_pixel(r, g, b, a, base, quiet);
    endtask

    // Write the target once the block has drained.
    task automatic write_target(input logic [CFG_W-1:0] v);
        s_valid <= 1'b0;
        while (cut_expected.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        tgt_color  = v;
    endtask

    // Random pixels biased toward target and black masks so that outlines form.
    task automatic run_random(input int count);
        int               k;
        logic [CFG_W-1:0] rgb;
        logic [7:0]       a;
        logic [31:0]      base;
        for (int n = 0; n < count; n++) begin
            k    = $urandom_range(0, 99);
            rgb  = CFG_W'($urandom);
            a    = 8'($urandom);
            base = $urandom;
            if (k < 35) begin
                rgb = tgt_color;
                a   = ALPHA_OPAQUE;
            end else if (k < 45) begin
                rgb = tgt_color;
            end else if (k < 75) begin
                rgb = '0;
            end else if (k < 80) begin
                rgb = tgt_color ^ (24'h1 << $urandom_range(0, 23));
            end
            send_pixel(rgb[23:16], rgb[15:8], rgb[7:0], a, base, 1'b0);
        end
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_fail++;
        end
    endtask

    // Compare one output transfer with the oldest expected pixel.
    task automatic check_pixel();
        cut_px_t want;
        n_results++;
        if (cut_expected.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual color %h col %0d row %0d",
                     $time, m_axis_tdata[31:0], m_axis_tdata[36:32], m_axis_tdata[41:37]);
            n_fail++;
            return;
        end
        want = cut_expected.pop_front();
        cmp_field("pixel_opaque", 32'(want.opaque), 32'(m_axis_tuser));
        cmp_field("pixel_color", want.color, m_axis_tdata[31:0]);
        cmp_field("out_col", 32'(want.col), 32'(m_axis_tdata[36:32]));
        cmp_field("out_row", 32'(want.row), 32'(m_axis_tdata[41:37]));
        cmp_field("zero fill", 32'h0, 32'(m_axis_tdata[47:42]));
        cmp_field("last_of_run", 32'(want.last), 32'(m_axis_tlast));
    endtask

    // Output transfers are sampled midway through the cycle, before the edge that takes them.
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_ready) check_pixel();
    end

    // Receiver: random stalls, plus one long hold-off while input keeps coming.
    initial begin : rx_side
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!hold_done && n_results >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                stall_left = RX_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready    <= 1'b1;
                stall_left  = pick_gap(rx_calm);
            end
        end
    end

    // Main sequence: reset, directed pixels, then random phases under several targets.
    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_target(TGT_A);
        for (int i = 0; i < PROBE_N; i++) begin
            send_pixel(probe_rows[i].r, probe_rows[i].g, probe_rows[i].b, probe_rows[i].a,
                       probe_rows[i].base, probe_rows[i].quiet);
        end

        // Continue the first window and change the target several times mid-window.
        run_random(95);
        write_target(24'hFFFFFF);
        run_random(50);
        write_target(24'h000000);
        run_random(50);
        write_target(CFG_W'($urandom));
        run_random(50);

        s_valid <= 1'b0;
        while (cut_expected.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard limit on the run time.
    initial begin : watchdog
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
